FILE: design/d96c_pkg.sv
// Shared types, widths and constants for the scaled decimal comparator.
// Holds the power-of-ten table and the relation codes; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package d96c_pkg;

    localparam int MANT_W        = 96;
    localparam int LO_W          = 64;
    localparam int HI_W          = 32;
    localparam int SCALE_W       = 5;
    localparam int ACTION_W      = 3;
    localparam int DEF_MAX_SCALE = 28;

    // Multiplier geometry: 96-bit operands cut into 32-bit limbs
    localparam int LIMB_W  = 32;
    localparam int LIMBS   = MANT_W / LIMB_W;
    localparam int PP_W    = 2 * LIMB_W;
    localparam int COLS    = 2 * LIMBS - 1;
    localparam int COL_W   = PP_W + 2;
    localparam int PROD_W  = 2 * MANT_W;
    localparam int SUM_W   = PROD_W + 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LT = 3'd0,
        ACT_LE = 3'd1,
        ACT_GT = 3'd2,
        ACT_GE = 3'd3,
        ACT_EQ = 3'd4,
        ACT_NE = 3'd5
    } action_t;

    // Per-transaction sideband carried alongside the multiplier
    typedef struct packed {
        logic                swapped;    // b was scaled up, a is the plain operand
        logic                a_neg;
        logic                b_neg;
        logic                both_zero;
        logic [ACTION_W-1:0] action;
    } side_t;

    // Load enables of the multiplier stages
    typedef struct packed {
        logic pp;
        logic col;
        logic sum;
    } mul_en_t;

    function automatic logic [MANT_W-1:0] pow10(input logic [SCALE_W-1:0] idx);
        logic [MANT_W-1:0] p;
        unique case (idx)
            5'd0:  p = 96'd1;
            5'd1:  p = 96'd10;
            5'd2:  p = 96'd100;
            5'd3:  p = 96'd1000;
            5'd4:  p = 96'd10000;
            5'd5:  p = 96'd100000;
            5'd6:  p = 96'd1000000;
            5'd7:  p = 96'd10000000;
            5'd8:  p = 96'd100000000;
            5'd9:  p = 96'd1000000000;
            5'd10: p = 96'd10000000000;
            5'd11: p = 96'd100000000000;
            5'd12: p = 96'd1000000000000;
            5'd13: p = 96'd10000000000000;
            5'd14: p = 96'd100000000000000;
            5'd15: p = 96'd1000000000000000;
            5'd16: p = 96'd10000000000000000;
            5'd17: p = 96'd100000000000000000;
            5'd18: p = 96'd1000000000000000000;
            5'd19: p = 96'd10000000000000000000;
            5'd20: p = 96'd100000000000000000000;
            5'd21: p = 96'd1000000000000000000000;
            5'd22: p = 96'd10000000000000000000000;
            5'd23: p = 96'd100000000000000000000000;
            5'd24: p = 96'd1000000000000000000000000;
            5'd25: p = 96'd10000000000000000000000000;
            5'd26: p = 96'd100000000000000000000000000;
            5'd27: p = 96'd1000000000000000000000000000;
            5'd28: p = 96'd10000000000000000000000000000;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

FILE: design/d96c_mul.sv
// Pipelined 96 x 96 unsigned multiplier: partial products, column sums, final sum.
// Three register stages, each loaded by its own enable; uses d96c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module d96c_mul (
    input  wire logic                          clk,
    input  wire d96c_pkg::mul_en_t             en,
    input  wire logic [d96c_pkg::MANT_W-1:0]   mcand,
    input  wire logic [d96c_pkg::MANT_W-1:0]   mplier,
    output logic      [d96c_pkg::PROD_W-1:0]   product
);
    import d96c_pkg::*;

    logic [PP_W-1:0]   pp_reg  [LIMBS][LIMBS];
    logic [COL_W-1:0]  col_next [COLS];
    logic [COL_W-1:0]  col_reg  [COLS];
    logic [SUM_W-1:0]  sum_acc;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;

    // 32 x 32 limb products
    always_ff @(posedge clk)
    begin
        if (en.pp)
        begin
            for (int i = 0; i < LIMBS; i++)
            begin
                for (int j = 0; j < LIMBS; j++)
                begin
                    pp_reg[i][j] <= PP_W'(mcand[i*LIMB_W +: LIMB_W])
                                  * PP_W'(mplier[j*LIMB_W +: LIMB_W]);
                end
            end
        end
    end

    // gather products of equal weight
    always_comb
    begin
        for (int k = 0; k < COLS; k++)
        begin
            col_next[k] = '0;
        end
        for (int i = 0; i < LIMBS; i++)
        begin
            for (int j = 0; j < LIMBS; j++)
            begin
                col_next[i+j] = col_next[i+j] + COL_W'(pp_reg[i][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.col)
        begin
            for (int k = 0; k < COLS; k++)
            begin
                col_reg[k] <= col_next[k];
            end
        end
    end

    always_comb
    begin
        sum_acc = '0;
        for (int k = 0; k < COLS; k++)
        begin
            sum_acc = sum_acc + (SUM_W'(col_reg[k]) << (k * LIMB_W));
        end
        prod_next = sum_acc[PROD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule

`default_nettype wire

FILE: design/decimal96_compare.sv
// Top level of the scaled decimal comparator: scale alignment, pipeline control
// and the final relation test. Depends on d96c_pkg and d96c_mul.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------
//   in      | sink      | in_valid / in_stall   | action, a_*/b_* mant_lo, mant_hi,
//           |           |                       | scale, negative
//   out     | source    | out_valid / out_stall | verdict
//
// One transaction per cycle sustained while out_stall is low; the multiplier stages
// (limb products, column sums, final sum) lie between alignment and compare.
// Reset clears the stage valid bits only; no clearing pass is needed.
// A stall on the output holds the stages that are full and lets empty stages
// fill behind them, so in_stall rises only when every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

module decimal96_compare #(
    parameter int MAX_SCALE = d96c_pkg::DEF_MAX_SCALE
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [d96c_pkg::ACTION_W-1:0]    action,
    input  wire logic [d96c_pkg::LO_W-1:0]        a_mant_lo,
    input  wire logic [d96c_pkg::HI_W-1:0]        a_mant_hi,
    input  wire logic [d96c_pkg::SCALE_W-1:0]     a_scale,
    input  wire logic                             a_negative,
    input  wire logic [d96c_pkg::LO_W-1:0]        b_mant_lo,
    input  wire logic [d96c_pkg::HI_W-1:0]        b_mant_hi,
    input  wire logic [d96c_pkg::SCALE_W-1:0]     b_scale,
    input  wire logic                             b_negative,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  verdict
);
    import d96c_pkg::*;

    localparam int STAGES = 5;
    localparam logic [SCALE_W-1:0] SCALE_CAP = SCALE_W'(MAX_SCALE);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   adv;

    logic [MANT_W-1:0]  a_mant;
    logic [MANT_W-1:0]  b_mant;
    logic [SCALE_W-1:0] sa;
    logic [SCALE_W-1:0] sb;
    side_t              side_next;
    logic [MANT_W-1:0]  mcand_next;
    logic [MANT_W-1:0]  pow_next;
    logic [MANT_W-1:0]  y_next;

    logic [MANT_W-1:0]  mcand_reg;
    logic [MANT_W-1:0]  pow_reg;
    side_t              side_reg [STAGES-1];
    logic [MANT_W-1:0]  y_reg    [STAGES-1];

    mul_en_t            mul_en;
    logic [PROD_W-1:0]  product;

    logic prod_gt;
    logic prod_eq;
    logic mag_lt;
    logic a_lt;
    logic a_eq;
    logic verdict_next;
    logic verdict_reg;
    side_t last_side;

    // A stage may load when it is empty or its contents move on
    always_comb
    begin
        adv[STAGES] = !out_stall;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign verdict   = verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: clamp scales, pick the lower-scale mantissa and its power of ten
    always_comb
    begin
        a_mant = {a_mant_hi, a_mant_lo};
        b_mant = {b_mant_hi, b_mant_lo};
        sa = (a_scale > SCALE_CAP) ? SCALE_CAP : a_scale;
        sb = (b_scale > SCALE_CAP) ? SCALE_CAP : b_scale;

        side_next.a_neg     = a_negative;
        side_next.b_neg     = b_negative;
        side_next.both_zero = (a_mant == '0) && (b_mant == '0);
        side_next.action    = action;

        if (sa <= sb)
        begin
            side_next.swapped = 1'b0;
            mcand_next        = a_mant;
            pow_next          = pow10(sb - sa);
            y_next            = b_mant;
        end
        else
        begin
            side_next.swapped = 1'b1;
            mcand_next        = b_mant;
            pow_next          = pow10(sa - sb);
            y_next            = a_mant;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mcand_reg   <= mcand_next;
            pow_reg     <= pow_next;
            side_reg[0] <= side_next;
            y_reg[0]    <= y_next;
        end
        for (int k = 1; k < STAGES - 1; k++)
        begin
            if (adv[k])
            begin
                side_reg[k] <= side_reg[k-1];
                y_reg[k]    <= y_reg[k-1];
            end
        end
    end

    // Stages 2 to 4: scale the lower-scale mantissa up
    always_comb
    begin
        mul_en.pp  = adv[1];
        mul_en.col = adv[2];
        mul_en.sum = adv[3];
    end

    d96c_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .mcand   (mcand_reg),
        .mplier  (pow_reg),
        .product (product)
    );

    // Stage 5: compare magnitudes and test the relation
    always_comb
    begin
        last_side = side_reg[STAGES-2];
        prod_gt   = product > {{(PROD_W-MANT_W){1'b0}}, y_reg[STAGES-2]};
        prod_eq   = product == {{(PROD_W-MANT_W){1'b0}}, y_reg[STAGES-2]};
        // product stands for a unless the operands were swapped
        mag_lt    = last_side.swapped ? prod_gt : (!prod_gt && !prod_eq);

        if (last_side.both_zero)
        begin
            a_lt = 1'b0;
            a_eq = 1'b1;
        end
        else if (last_side.a_neg != last_side.b_neg)
        begin
            a_lt = last_side.a_neg;
            a_eq = 1'b0;
        end
        else
        begin
            a_eq = prod_eq;
            // both negative: reverse the magnitude order
            a_lt = last_side.a_neg ? (!mag_lt && !prod_eq) : mag_lt;
        end

        unique case (action_t'(last_side.action))
            ACT_LT:  verdict_next = a_lt;
            ACT_LE:  verdict_next = a_lt || a_eq;
            ACT_GT:  verdict_next = !a_lt && !a_eq;
            ACT_GE:  verdict_next = !a_lt;
            ACT_EQ:  verdict_next = a_eq;
            ACT_NE:  verdict_next = !a_eq;
            default: verdict_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[STAGES-1])
        begin
            verdict_reg <= verdict_next;
        end
    end

    // Input is held off only when the whole pipe is full and blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled with room in the pipeline");

    // A full stage that cannot move keeps its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && !adv[3]) |=> valid_reg[2])
        else $error("transaction lost from a held stage");

    // Two zeros test equal whatever their signs
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES-2] && adv[STAGES-1] && side_reg[STAGES-2].both_zero
         && (side_reg[STAGES-2].action == ACT_EQ)) |=> verdict_reg)
        else $error("zeros did not compare equal");

    // Unused relation codes give a false verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES-2] && adv[STAGES-1]
         && (side_reg[STAGES-2].action[2:1] == 2'b11)) |=> !verdict_reg)
        else $error("unused relation code gave a true verdict");

endmodule

`default_nettype wire
